@@ rtl/bocc_pkg.sv @@
// ----------------------------------------------------------------------------
// Box obstacle collision check: shared package
// Types and constants used by the lanes, the goal check and the top level.
// ----------------------------------------------------------------------------
package bocc_pkg;

  // Three spatial axes, one lane each.
  localparam int unsigned AXES = 3;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned MARGIN_W = 30;
  localparam int unsigned TOTAL_W  = 7;

  // Opcodes of an input item.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MARGIN   = 3'd0;
  localparam logic [2:0] REG_GOAL_CX  = 3'd1;
  localparam logic [2:0] REG_GOAL_CY  = 3'd2;
  localparam logic [2:0] REG_GOAL_CZ  = 3'd3;
  localparam logic [2:0] REG_GOAL_SX  = 3'd4;
  localparam logic [2:0] REG_GOAL_SY  = 3'd5;
  localparam logic [2:0] REG_GOAL_SZ  = 3'd6;

  // Write request into one axis lane's box memory.
  typedef struct packed {
    logic                       en;
    logic signed [COORD_W-1:0]  center;
    logic [SIZE_W-1:0]          size;
  } lane_wr_t;

endpackage

@@ rtl/bocc_axis_lane.sv @@
// ----------------------------------------------------------------------------
// Box obstacle collision check: axis lane
// Holds one axis of every stored box and tests the query point on that axis.
// ----------------------------------------------------------------------------
module bocc_axis_lane #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                                    clk,
  input  bocc_pkg::lane_wr_t                      wr,
  input  logic [AW-1:0]                           wr_addr,
  input  logic                                    rd_en,
  input  logic [AW-1:0]                           rd_addr,
  input  logic signed [bocc_pkg::COORD_W-1:0]     point,
  input  logic [bocc_pkg::MARGIN_W-1:0]           margin,
  output logic                                    hit
);

  localparam int unsigned EW = bocc_pkg::COORD_W + bocc_pkg::SIZE_W;

  logic [EW-1:0] store [DEPTH];
  logic [EW-1:0] rd_entry;

  logic signed [bocc_pkg::COORD_W-1:0] center;
  logic [bocc_pkg::SIZE_W-1:0]         size;
  logic signed [bocc_pkg::COORD_W:0]   diff_fwd;
  logic signed [bocc_pkg::COORD_W:0]   diff_rev;
  logic [bocc_pkg::COORD_W-1:0]        abs_now;
  logic [bocc_pkg::COORD_W-1:0]        abs_diff;
  logic [bocc_pkg::COORD_W-1:0]        limit;

  // Memory: one write port for adds, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr_addr] <= {wr.center, wr.size};
    end
    if (rd_en) begin
      rd_entry <= store[rd_addr];
    end
  end

  assign center   = rd_entry[EW-1:bocc_pkg::SIZE_W];
  assign size     = rd_entry[bocc_pkg::SIZE_W-1:0];
  assign diff_fwd = {center[bocc_pkg::COORD_W-1], center} - {point[bocc_pkg::COORD_W-1], point};
  assign diff_rev = {point[bocc_pkg::COORD_W-1], point} - {center[bocc_pkg::COORD_W-1], center};
  assign abs_now  = diff_fwd[bocc_pkg::COORD_W] ? diff_rev[bocc_pkg::COORD_W-1:0]
                                                : diff_fwd[bocc_pkg::COORD_W-1:0];

  // Distance and inflated extent, then the strict compare of 2|d| against it.
  always_ff @(posedge clk) begin
    abs_diff <= abs_now;
    limit    <= {1'b0, size} + {1'b0, margin, 1'b0};
    hit      <= {abs_diff, 1'b0} < {1'b0, limit};
  end

endmodule

@@ rtl/bocc_goal_check.sv @@
// ----------------------------------------------------------------------------
// Box obstacle collision check: goal check
// Tests whether a query point lies in the goal box, boundary included.
// ----------------------------------------------------------------------------
module bocc_goal_check (
  input  logic                                  clk,
  input  logic                                  capture,
  input  logic signed [bocc_pkg::COORD_W-1:0]   point       [bocc_pkg::AXES],
  input  logic signed [bocc_pkg::COORD_W-1:0]   goal_center [bocc_pkg::AXES],
  input  logic [bocc_pkg::SIZE_W-1:0]           goal_size   [bocc_pkg::AXES],
  output logic                                  at_goal
);

  logic [bocc_pkg::COORD_W-1:0] abs_diff [bocc_pkg::AXES];
  logic [bocc_pkg::AXES-1:0]    axis_ok;

  always_ff @(posedge clk) begin
    for (int a = 0; a < bocc_pkg::AXES; a++) begin
      logic signed [bocc_pkg::COORD_W:0] fwd;
      logic signed [bocc_pkg::COORD_W:0] rev;
      fwd = {point[a][bocc_pkg::COORD_W-1], point[a]}
          - {goal_center[a][bocc_pkg::COORD_W-1], goal_center[a]};
      rev = {goal_center[a][bocc_pkg::COORD_W-1], goal_center[a]}
          - {point[a][bocc_pkg::COORD_W-1], point[a]};
      if (capture) begin
        abs_diff[a] <= fwd[bocc_pkg::COORD_W] ? rev[bocc_pkg::COORD_W-1:0]
                                              : fwd[bocc_pkg::COORD_W-1:0];
      end
    end
    at_goal <= &axis_ok;
  end

  always_comb begin
    for (int a = 0; a < bocc_pkg::AXES; a++) begin
      axis_ok[a] = {abs_diff[a], 1'b0} <= {2'b00, goal_size[a]};
    end
  end

endmodule

@@ rtl/bocc_merge.sv @@
// ----------------------------------------------------------------------------
// Box obstacle collision check: lane merge
// Combines the per-axis hits of each box and accumulates over the scan.
// ----------------------------------------------------------------------------
module bocc_merge (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        hit_valid,
  input  logic [bocc_pkg::AXES-1:0]   hits,
  output logic                        collision
);

  // A box is hit only when every axis lane reports the point inside.
  always_ff @(posedge clk) begin
    if (clr) begin
      collision <= 1'b0;
    end else if (hit_valid && (&hits)) begin
      collision <= 1'b1;
    end
  end

endmodule

@@ rtl/box_obstacle_collision_check_unit.sv @@
// ----------------------------------------------------------------------------
// Box obstacle collision check unit
// Operation: a clear, an add or an unused opcode passes through FINISH to the
// output register; a query first scans the lane memories, reading one stored
// box per cycle, and lets the lane pipeline drain before its result moves on.
// Throughput: one item at a time; the next transfer is taken once the result
// has moved to the output register. Reset (synchronous) empties the table and
// zeroes the configuration registers; the box memories themselves are not
// cleared.
// ----------------------------------------------------------------------------
module box_obstacle_collision_check_unit #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            opcode,
  input  logic signed [31:0]                    box_center_x,
  input  logic signed [31:0]                    box_center_y,
  input  logic signed [31:0]                    box_center_z,
  input  logic [30:0]                           box_size_x,
  input  logic [30:0]                           box_size_y,
  input  logic [30:0]                           box_size_z,
  input  logic signed [31:0]                    point_x,
  input  logic signed [31:0]                    point_y,
  input  logic signed [31:0]                    point_z,
  // Output channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  in_collision,
  output logic                                  at_goal,
  output logic                                  add_rejected,
  output logic [6:0]                            box_total,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [4:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // Address width of the lane memories and width of the box counter, which
  // must be able to hold MAX_BOXES itself.
  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  // Sequencer states. SCAN issues one memory read per stored box, DRAIN lets
  // the three-stage lane pipeline empty, FINISH waits for the output register.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          accept;
  logic          table_full;
  logic          rd_en;
  logic          v2;
  logic          v3;
  logic          v1;
  logic          load_out;

  // Configuration registers.
  logic [bocc_pkg::MARGIN_W-1:0]         safety_margin;
  logic signed [bocc_pkg::COORD_W-1:0]   goal_center [bocc_pkg::AXES];
  logic [bocc_pkg::SIZE_W-1:0]           goal_size   [bocc_pkg::AXES];
  logic                                  cfg_write;

  // Query point held during the scan, and the per-lane inputs.
  logic signed [bocc_pkg::COORD_W-1:0]   pt        [bocc_pkg::AXES];
  logic signed [bocc_pkg::COORD_W-1:0]   in_point  [bocc_pkg::AXES];
  logic signed [bocc_pkg::COORD_W-1:0]   in_center [bocc_pkg::AXES];
  logic [bocc_pkg::SIZE_W-1:0]           in_size   [bocc_pkg::AXES];
  bocc_pkg::lane_wr_t                    lane_wr   [bocc_pkg::AXES];
  logic [bocc_pkg::AXES-1:0]             lane_hit;

  logic merge_clr;
  logic collision;
  logic goal_hit;

  // Result waiting to be moved into the output register.
  logic                           pend_coll;
  logic                           pend_goal;
  logic                           pend_rej;
  logic [bocc_pkg::TOTAL_W-1:0]   pend_total;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; reads return the
  // register values, the margin and the sizes zero-extended.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_margin <= '0;
      for (int a = 0; a < bocc_pkg::AXES; a++) begin
        goal_center[a] <= '0;
        goal_size[a]   <= '0;
      end
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        bocc_pkg::REG_MARGIN:  safety_margin  <= pwdata[bocc_pkg::MARGIN_W-1:0];
        bocc_pkg::REG_GOAL_CX: goal_center[0] <= pwdata;
        bocc_pkg::REG_GOAL_CY: goal_center[1] <= pwdata;
        bocc_pkg::REG_GOAL_CZ: goal_center[2] <= pwdata;
        bocc_pkg::REG_GOAL_SX: goal_size[0]   <= pwdata[bocc_pkg::SIZE_W-1:0];
        bocc_pkg::REG_GOAL_SY: goal_size[1]   <= pwdata[bocc_pkg::SIZE_W-1:0];
        bocc_pkg::REG_GOAL_SZ: goal_size[2]   <= pwdata[bocc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bocc_pkg::REG_MARGIN:  prdata = {2'b00, safety_margin};
      bocc_pkg::REG_GOAL_CX: prdata = goal_center[0];
      bocc_pkg::REG_GOAL_CY: prdata = goal_center[1];
      bocc_pkg::REG_GOAL_CZ: prdata = goal_center[2];
      bocc_pkg::REG_GOAL_SX: prdata = {1'b0, goal_size[0]};
      bocc_pkg::REG_GOAL_SY: prdata = {1'b0, goal_size[1]};
      bocc_pkg::REG_GOAL_SZ: prdata = {1'b0, goal_size[2]};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input transfers and the lane write requests.
  // --------------------------------------------------------------------------
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign table_full = (count == CW'(MAX_BOXES));
  assign merge_clr  = accept && (opcode == bocc_pkg::OP_QUERY);

  assign in_point[0]  = point_x;
  assign in_point[1]  = point_y;
  assign in_point[2]  = point_z;
  assign in_center[0] = box_center_x;
  assign in_center[1] = box_center_y;
  assign in_center[2] = box_center_z;
  assign in_size[0]   = box_size_x;
  assign in_size[1]   = box_size_y;
  assign in_size[2]   = box_size_z;

  always_comb begin
    for (int a = 0; a < bocc_pkg::AXES; a++) begin
      lane_wr[a].en     = accept && (opcode == bocc_pkg::OP_ADD) && !table_full;
      lane_wr[a].center = in_center[a];
      lane_wr[a].size   = in_size[a];
    end
  end

  // One read per cycle while boxes remain to be scanned.
  assign rd_en = (state == ST_SCAN) && (scan_idx < count);

  // --------------------------------------------------------------------------
  // Three axis lanes work side by side on the same box, then merge.
  // --------------------------------------------------------------------------
  for (genvar a = 0; a < bocc_pkg::AXES; a++) begin : g_lane
    bocc_axis_lane #(
      .DEPTH (MAX_BOXES),
      .AW    (AW)
    ) u_lane (
      .clk     (clk),
      .wr      (lane_wr[a]),
      .wr_addr (count[AW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (scan_idx[AW-1:0]),
      .point   (pt[a]),
      .margin  (safety_margin),
      .hit     (lane_hit[a])
    );
  end

  bocc_merge u_merge (
    .clk       (clk),
    .clr       (merge_clr),
    .hit_valid (v3),
    .hits      (lane_hit),
    .collision (collision)
  );

  // The goal check captures the point at the transfer; its answer is registered
  // and ready before the sequencer can leave DRAIN.
  bocc_goal_check u_goal (
    .clk         (clk),
    .capture     (merge_clr),
    .point       (in_point),
    .goal_center (goal_center),
    .goal_size   (goal_size),
    .at_goal     (goal_hit)
  );

  // --------------------------------------------------------------------------
  // Sequencer, box counter and scan pipeline valid flags.
  // --------------------------------------------------------------------------
  assign load_out = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode)
              bocc_pkg::OP_CLEAR: begin
                count <= '0;
                state <= ST_FINISH;
              end
              bocc_pkg::OP_ADD: begin
                if (!table_full) begin
                  count <= count + CW'(1);
                end
                state <= ST_FINISH;
              end
              bocc_pkg::OP_QUERY: begin
                scan_idx <= '0;
                state    <= ST_SCAN;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + CW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: held query point, pending result and output.
  always_ff @(posedge clk) begin
    if (merge_clr) begin
      for (int a = 0; a < bocc_pkg::AXES; a++) begin
        pt[a] <= in_point[a];
      end
    end
    if (accept) begin
      pend_coll <= 1'b0;
      pend_goal <= 1'b0;
      pend_rej  <= (opcode == bocc_pkg::OP_ADD) && table_full;
      if (opcode == bocc_pkg::OP_CLEAR) begin
        pend_total <= '0;
      end else if ((opcode == bocc_pkg::OP_ADD) && !table_full) begin
        pend_total <= bocc_pkg::TOTAL_W'(count + CW'(1));
      end else begin
        pend_total <= bocc_pkg::TOTAL_W'(count);
      end
    end else if ((state == ST_DRAIN) && !v1 && !v2 && !v3) begin
      pend_coll  <= collision;
      pend_goal  <= goal_hit;
      pend_total <= bocc_pkg::TOTAL_W'(count);
    end
    if (load_out) begin
      in_collision <= pend_coll;
      at_goal      <= pend_goal;
      add_rejected <= pend_rej;
      box_total    <= pend_total;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BOXES))
    else $error("box counter exceeds table size");

  a_hit_in_scan : assert property (@(posedge clk) disable iff (rst)
    v3 |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("lane hit outside a query scan");

  a_reject_full : assert property (@(posedge clk) disable iff (rst)
    load_out && pend_rej |-> table_full)
    else $error("add rejected while the table had room");

  a_busy_after : assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("new transfer taken before the previous item finished");

endmodule
